/* hw/rtl/spr_pkg.sv */
// Shared types, constants and codes of the shelf rectangle packer.
package spr_pkg;

  // Capacity of the rectangle store and the widths that follow from it.
  localparam int unsigned MAX_RECTS = 32;
  localparam int unsigned IDX_W     = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int unsigned CNT_W     = $clog2(MAX_RECTS + 1);

  // Field widths of the ports.
  localparam int unsigned SIZE_W     = 15;
  localparam int unsigned POS_W      = 14;
  localparam int unsigned RIDX_W     = 5;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned AREA_W     = 34;
  localparam int unsigned PROD_W     = 2 * SIZE_W;
  localparam int unsigned SIDE_W     = SIZE_W + 1;
  localparam int unsigned CFG_IDX_W  = 1;

  // Configuration register indexes and reset values.
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_ATLAS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATLAS = 1'b1;
  localparam logic [SIZE_W-1:0]    MIN_ATLAS_RST = 15'd16;
  localparam logic [SIZE_W-1:0]    MAX_ATLAS_RST = 15'd4096;

  // Result kinds.
  localparam logic KIND_PLACE   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_SIZE = 2'd1,
    STATUS_FIT  = 2'd2
  } status_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_SIZE_MUL,
    ST_SIZE_CHK,
    ST_PL_READ,
    ST_PL_WRAP,
    ST_PL_FIT,
    ST_SUMMARY
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic size_init;
    logic size_mul;
    logic size_double;
    logic emit_size_err;
    logic place_init;
    logic place_wrap;
    logic place_fit;
    logic emit_done;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic size_ok;
    logic size_ovf;
    logic fit_fail;
    logic last_rect;
  } dp_status_t;

endpackage

/* hw/rtl/spr_ctrl.sv */
// Controller state machine of the shelf rectangle packer.
module spr_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  logic                final_rect_i,
  input  spr_pkg::dp_status_t status_i,
  output spr_pkg::dp_cmd_t    cmd_o,
  output logic                busy
);
  import spr_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start && final_rect_i) begin
          state_d = ST_ACCUM;
        end
      end
      ST_ACCUM:    state_d = ST_SIZE_MUL;
      ST_SIZE_MUL: state_d = ST_SIZE_CHK;
      ST_SIZE_CHK: begin
        if (status_i.size_ok) begin
          state_d = ST_PL_READ;
        end else if (status_i.size_ovf) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_SIZE_MUL;
        end
      end
      ST_PL_READ: state_d = ST_PL_WRAP;
      ST_PL_WRAP: state_d = ST_PL_FIT;
      ST_PL_FIT: begin
        if (status_i.fit_fail) begin
          state_d = ST_IDLE;
        end else if (status_i.last_rect) begin
          state_d = ST_SUMMARY;
        end else begin
          state_d = ST_PL_READ;
        end
      end
      ST_SUMMARY: state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Commands issued in each state.
  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE:     cmd_o.load = start;
      ST_ACCUM:    cmd_o.size_init = 1'b1;
      ST_SIZE_MUL: cmd_o.size_mul = 1'b1;
      ST_SIZE_CHK: begin
        if (status_i.size_ok) begin
          cmd_o.place_init = 1'b1;
        end else begin
          cmd_o.size_double   = 1'b1;
          cmd_o.emit_size_err = status_i.size_ovf;
        end
      end
      ST_PL_READ:  cmd_o = '0;
      ST_PL_WRAP:  cmd_o.place_wrap = 1'b1;
      ST_PL_FIT:   cmd_o.place_fit = 1'b1;
      ST_SUMMARY:  cmd_o.emit_done = 1'b1;
      default:     cmd_o = '0;
    endcase
  end

  assign busy = (state_q != ST_IDLE);

endmodule

/* hw/rtl/spr_dpath.sv */
// Datapath of the shelf rectangle packer: store, totals, sizing and placement.
module spr_dpath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  spr_pkg::dp_cmd_t                cmd_i,
  output spr_pkg::dp_status_t             status_o,
  input  logic [spr_pkg::SIZE_W-1:0]      rect_width_i,
  input  logic [spr_pkg::SIZE_W-1:0]      rect_height_i,
  input  logic                            cfg_we_i,
  input  logic [spr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [spr_pkg::SIZE_W-1:0]      cfg_wdata_i,
  output logic                            result_valid_o,
  output logic                            kind_o,
  output logic [spr_pkg::RIDX_W-1:0]      rect_index_o,
  output logic [spr_pkg::POS_W-1:0]       pos_x_o,
  output logic [spr_pkg::POS_W-1:0]       pos_y_o,
  output logic [spr_pkg::SIZE_W-1:0]      atlas_width_o,
  output logic [spr_pkg::SIZE_W-1:0]      atlas_height_o,
  output logic [spr_pkg::STATUS_W-1:0]    res_status_o,
  output logic                            run_end_o
);
  import spr_pkg::*;

  // Configuration registers.
  logic [SIZE_W-1:0] min_size_q, max_size_q;

  // Set totals.
  logic [CNT_W-1:0]  count_q;
  logic [AREA_W-1:0] area_q;
  logic [SIZE_W-1:0] widest_q, tallest_q;
  logic [PROD_W-1:0] prod_q;
  logic              prod_vld_q;

  // Sizing.
  logic [SIDE_W-1:0] aw_q, ah_q;
  logic [PROD_W-1:0] side_prod_q;

  // Placement.
  logic [IDX_W-1:0]  idx_q;
  logic [SIZE_W-1:0] cx_q, cy_q, shelf_q;

  // Rectangle store: width and height side by side.
  logic [2*SIZE_W-1:0] store_mem [MAX_RECTS];
  logic [2*SIZE_W-1:0] rd_q;
  logic [SIZE_W-1:0]   rw, rh;

  // Result register.
  logic                res_valid_q;
  logic                kind_q, run_end_q;
  logic [RIDX_W-1:0]   ridx_q;
  logic [POS_W-1:0]    px_q, py_q;
  logic [SIZE_W-1:0]   aw_out_q, ah_out_q;
  logic [STATUS_W-1:0] st_q;

  logic              store_ok;
  logic              clear_set;
  logic [SIZE_W-1:0] min_eff;
  logic              double_w;
  logic [SIDE_W-1:0] side_dbl;
  logic [SIDE_W-1:0] wrap_sum, shelf_sum, fit_sum;
  logic              fit_fail;

  assign store_ok = (count_q < CNT_W'(MAX_RECTS));
  assign min_eff  = (min_size_q == '0) ? SIZE_W'(1) : min_size_q;
  assign rw       = rd_q[2*SIZE_W-1:SIZE_W];
  assign rh       = rd_q[SIZE_W-1:0];

  // The smaller side doubles; height doubles on a tie.
  assign double_w = (aw_q < ah_q);
  assign side_dbl = double_w ? {aw_q[SIDE_W-2:0], 1'b0} : {ah_q[SIDE_W-2:0], 1'b0};

  // Shelf arithmetic.
  assign wrap_sum  = SIDE_W'(cx_q) + SIDE_W'(rw);
  assign shelf_sum = SIDE_W'(cy_q) + SIDE_W'(shelf_q);
  assign fit_sum   = SIDE_W'(cy_q) + SIDE_W'(rh);
  assign fit_fail  = (fit_sum > ah_q);

  assign status_o.size_ok   = (AREA_W'(side_prod_q) >= area_q) &&
                              (aw_q >= SIDE_W'(widest_q)) && (ah_q >= SIDE_W'(tallest_q));
  assign status_o.size_ovf  = (side_dbl > SIDE_W'(max_size_q));
  assign status_o.fit_fail  = fit_fail;
  assign status_o.last_rect = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);

  assign clear_set = cmd_i.emit_size_err || cmd_i.emit_done ||
                     (cmd_i.place_fit && fit_fail);

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_size_q <= MIN_ATLAS_RST;
      max_size_q <= MAX_ATLAS_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_MIN_ATLAS) begin
        min_size_q <= cfg_wdata_i;
      end
      if (cfg_idx_i == CFG_MAX_ATLAS) begin
        max_size_q <= cfg_wdata_i;
      end
    end
  end

  // Store write and registered read at the placement index.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && store_ok) begin
      store_mem[count_q[IDX_W-1:0]] <= {rect_width_i, rect_height_i};
    end
    rd_q <= store_mem[idx_q];
  end

  // Area product of each loaded rectangle, added to the total in the next cycle, and of the atlas sides.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && store_ok) begin
      prod_q <= PROD_W'(rect_width_i) * PROD_W'(rect_height_i);
    end
    if (cmd_i.size_mul) begin
      side_prod_q <= PROD_W'(aw_q[SIZE_W-1:0]) * PROD_W'(ah_q[SIZE_W-1:0]);
    end
  end

  // Set totals.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      area_q     <= '0;
      widest_q   <= '0;
      tallest_q  <= '0;
      prod_vld_q <= 1'b0;
    end else if (clear_set) begin
      count_q    <= '0;
      area_q     <= '0;
      widest_q   <= '0;
      tallest_q  <= '0;
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= cmd_i.load && store_ok;
      if (prod_vld_q) begin
        area_q <= area_q + AREA_W'(prod_q);
      end
      if (cmd_i.load && store_ok) begin
        count_q <= count_q + CNT_W'(1);
        if (rect_width_i > widest_q) begin
          widest_q <= rect_width_i;
        end
        if (rect_height_i > tallest_q) begin
          tallest_q <= rect_height_i;
        end
      end
    end
  end

  // Atlas sides: start at the minimum and double the smaller one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      aw_q <= '0;
      ah_q <= '0;
    end else if (cmd_i.size_init) begin
      aw_q <= SIDE_W'(min_eff);
      ah_q <= SIDE_W'(min_eff);
    end else if (cmd_i.size_double && !status_o.size_ovf) begin
      if (double_w) begin
        aw_q <= side_dbl;
      end else begin
        ah_q <= side_dbl;
      end
    end
  end

  // Shelf cursors and placement index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      cx_q    <= '0;
      cy_q    <= '0;
      shelf_q <= '0;
    end else if (cmd_i.place_init || clear_set) begin
      idx_q   <= '0;
      cx_q    <= '0;
      cy_q    <= '0;
      shelf_q <= '0;
    end else if (cmd_i.place_wrap) begin
      if (wrap_sum > aw_q) begin
        cx_q    <= '0;
        cy_q    <= shelf_sum[SIZE_W-1:0];
        shelf_q <= '0;
      end
    end else if (cmd_i.place_fit) begin
      if (rh > shelf_q) begin
        shelf_q <= rh;
      end
      cx_q  <= wrap_sum[SIZE_W-1:0];
      idx_q <= idx_q + IDX_W'(1);
    end
  end

  // Result strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.emit_size_err || cmd_i.emit_done || cmd_i.place_fit;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_size_err) begin
      kind_q    <= KIND_SUMMARY;
      ridx_q    <= '0;
      px_q      <= '0;
      py_q      <= '0;
      aw_out_q  <= '0;
      ah_out_q  <= '0;
      st_q      <= STATUS_SIZE;
      run_end_q <= 1'b1;
    end else if (cmd_i.emit_done) begin
      kind_q    <= KIND_SUMMARY;
      ridx_q    <= '0;
      px_q      <= '0;
      py_q      <= '0;
      aw_out_q  <= aw_q[SIZE_W-1:0];
      ah_out_q  <= ah_q[SIZE_W-1:0];
      st_q      <= STATUS_OK;
      run_end_q <= 1'b1;
    end else if (cmd_i.place_fit && fit_fail) begin
      kind_q    <= KIND_SUMMARY;
      ridx_q    <= RIDX_W'(idx_q);
      px_q      <= '0;
      py_q      <= '0;
      aw_out_q  <= aw_q[SIZE_W-1:0];
      ah_out_q  <= ah_q[SIZE_W-1:0];
      st_q      <= STATUS_FIT;
      run_end_q <= 1'b1;
    end else if (cmd_i.place_fit) begin
      kind_q    <= KIND_PLACE;
      ridx_q    <= RIDX_W'(idx_q);
      px_q      <= cx_q[POS_W-1:0];
      py_q      <= cy_q[POS_W-1:0];
      aw_out_q  <= '0;
      ah_out_q  <= '0;
      st_q      <= STATUS_OK;
      run_end_q <= 1'b0;
    end
  end

  assign result_valid_o = res_valid_q;
  assign kind_o         = kind_q;
  assign rect_index_o   = ridx_q;
  assign pos_x_o        = px_q;
  assign pos_y_o        = py_q;
  assign atlas_width_o  = aw_out_q;
  assign atlas_height_o = ah_out_q;
  assign res_status_o   = st_q;
  assign run_end_o      = run_end_q;

endmodule

/* hw/rtl/shelf_rectangle_packer_core.sv */
// Top level of the shelf rectangle packer: controller and datapath.
//
//   Channel   Handshake            Transfer moves
//   input     start, busy          rect_width_i, rect_height_i, final_rect_i
//   config    cfg_we_i             cfg_idx_i, cfg_wdata_i
//   result    result_valid_o       kind_o .. run_end_o, one cycle each
//
// Rectangles load at one per cycle while busy is low; the product for the
// running area is added in the cycle after. After the final rectangle the block
// is busy for accumulation, then for each sizing check (multiply, then compare and
// double), then for each placed rectangle (store read, shelf wrap, height check)
// and last for the summary; the store read step serves the store's registered
// read port. Results are registered and cannot be held off. Reset clears the
// totals and cursors; the store is not cleared.
module shelf_rectangle_packer_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [spr_pkg::SIZE_W-1:0]     rect_width_i,
  input  logic [spr_pkg::SIZE_W-1:0]     rect_height_i,
  input  logic                           final_rect_i,
  input  logic                           cfg_we_i,
  input  logic [spr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [spr_pkg::SIZE_W-1:0]     cfg_wdata_i,
  output logic                           result_valid_o,
  output logic                           kind_o,
  output logic [spr_pkg::RIDX_W-1:0]     rect_index_o,
  output logic [spr_pkg::POS_W-1:0]      pos_x_o,
  output logic [spr_pkg::POS_W-1:0]      pos_y_o,
  output logic [spr_pkg::SIZE_W-1:0]     atlas_width_o,
  output logic [spr_pkg::SIZE_W-1:0]     atlas_height_o,
  output logic [spr_pkg::STATUS_W-1:0]   status_o,
  output logic                           run_end_o
);
  import spr_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t dp_status;
  logic       start_acc;

  // An item is transferred only while the block is idle.
  assign start_acc = start && !busy;

  // Sequencing of load, sizing and placement.
  spr_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start_acc),
    .final_rect_i (final_rect_i),
    .status_i     (dp_status),
    .cmd_o        (cmd),
    .busy         (busy)
  );

  // Store, totals, sizing, shelf cursors and result register.
  spr_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (dp_status),
    .rect_width_i   (rect_width_i),
    .rect_height_i  (rect_height_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .kind_o         (kind_o),
    .rect_index_o   (rect_index_o),
    .pos_x_o        (pos_x_o),
    .pos_y_o        (pos_y_o),
    .atlas_width_o  (atlas_width_o),
    .atlas_height_o (atlas_height_o),
    .res_status_o   (status_o),
    .run_end_o      (run_end_o)
  );

endmodule

/* hw/rtl/spr_checker.sv */
// Port-level checker of the shelf rectangle packer and its bind.
module spr_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           busy,
  input logic                           result_valid_o,
  input logic                           kind_o,
  input logic [spr_pkg::SIZE_W-1:0]     atlas_width_o,
  input logic [spr_pkg::SIZE_W-1:0]     atlas_height_o,
  input logic [spr_pkg::STATUS_W-1:0]   status_o,
  input logic                           run_end_o
);
  import spr_pkg::*;

  // Only the summary closes a run.
  a_summary_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ((kind_o == KIND_SUMMARY) == run_end_o))
    else $error("run end flag does not match result kind");

  // A placement carries no status and no atlas size.
  a_place_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && kind_o == KIND_PLACE) |->
      (status_o == STATUS_OK && atlas_width_o == '0 && atlas_height_o == '0))
    else $error("placement carries summary fields");

  // A size error reports no atlas size.
  a_size_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && status_o == STATUS_SIZE) |->
      (atlas_width_o == '0 && atlas_height_o == '0))
    else $error("size error with an atlas size");

  // Placements arrive while the run is still in progress.
  a_place_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !run_end_o) |-> busy)
    else $error("placement while idle");

  // Nothing follows the closing summary straight away.
  a_quiet_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && run_end_o) |=> !result_valid_o)
    else $error("result directly after run end");

endmodule

bind shelf_rectangle_packer_core spr_checker u_spr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .kind_o         (kind_o),
  .atlas_width_o  (atlas_width_o),
  .atlas_height_o (atlas_height_o),
  .status_o       (status_o),
  .run_end_o      (run_end_o)
);
